// ----- rtl/core/spq_pkg.sv -----
// ============================================================================
// spq_pkg: shared types and constants of the stable priority queue
// Entry record, command bundle for the cell row and result status codes.
// ============================================================================
`default_nettype none

package spq_pkg;

    localparam int unsigned ID_W   = 16;
    localparam int unsigned PRI_W  = 4;
    localparam int unsigned AGE_W  = 8;
    localparam int unsigned OCC_W  = 5;
    localparam int unsigned STAT_W = 2;

    localparam logic [ID_W-1:0] FIRST_ID_RESET = 16'd101;

    // Operation codes of an input transaction.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STAT_W-1:0] ST_REMOVED  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

    // One stored queue entry.
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
        logic [AGE_W-1:0] age;
    } t_entry;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [PRI_W-1:0] pri;
    } t_cmd;

endpackage

`default_nettype wire

// ----- rtl/core/spq_in_if.sv -----
// ============================================================================
// spq_in_if: request channel of the stable priority queue
// Valid/ready handshake carrying one insert or remove request.
// ============================================================================
`default_nettype none

interface spq_in_if;
    logic                      valid;
    logic                      ready;
    logic                      op;
    logic [spq_pkg::PRI_W-1:0] priority_req;
    logic [spq_pkg::AGE_W-1:0] age;

    modport source (output valid, output op, output priority_req, output age,
                    input ready);
    modport sink   (input valid, input op, input priority_req, input age,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/core/spq_out_if.sv -----
// ============================================================================
// spq_out_if: result channel of the stable priority queue
// Valid/ready handshake carrying one result per request.
// ============================================================================
`default_nettype none

interface spq_out_if;
    logic                       valid;
    logic                       ready;
    logic [spq_pkg::STAT_W-1:0] status;
    logic [spq_pkg::ID_W-1:0]   entry_id;
    logic [spq_pkg::PRI_W-1:0]  entry_priority;
    logic [spq_pkg::AGE_W-1:0]  entry_age;
    logic [spq_pkg::OCC_W-1:0]  occupancy;

    modport source (output valid, output status, output entry_id,
                    output entry_priority, output entry_age, output occupancy,
                    input ready);
    modport sink   (input valid, input status, input entry_id,
                    input entry_priority, input entry_age, input occupancy,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/core/spq_cell.sv -----
// ============================================================================
// spq_cell: one slot of the sorted shift-register queue
// Holds an entry and picks its next value from itself, its neighbors or the
// new entry.
// ============================================================================
`default_nettype none

module spq_cell (
    input  wire               i_clk,
    input  spq_pkg::t_cmd     i_cmd,
    input  wire               i_occ,        // this slot holds a live entry
    input  wire               i_left_keep,  // left slot stays on insert
    input  spq_pkg::t_entry   i_new,
    input  spq_pkg::t_entry   i_left,
    input  spq_pkg::t_entry   i_right,
    output logic              o_keep,
    output spq_pkg::t_entry   o_entry
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;

    // An entry of equal or smaller priority value stays ahead of a new one,
    // which keeps entries of one level in arrival order.
    assign o_keep  = i_occ && (r_entry.pri <= i_cmd.pri);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.ins) begin
            if (o_keep) begin
                n_entry = r_entry;
            end else if (i_left_keep) begin
                n_entry = i_new;
            end else begin
                n_entry = i_left;
            end
        end else if (i_cmd.rem) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

// ----- rtl/core/stable_priority_queue_with_ids.sv -----
// ============================================================================
// stable_priority_queue_with_ids: bounded stable priority queue with IDs
// Sorted shift-register queue built from a row of cells, with sequence IDs.
// ============================================================================
// Latency: a result is registered in the cycle after its request transaction.
// Throughput: one transaction per cycle while results are taken; all cells
// compare and shift together; the cell row and single output register set it.
// Reset (synchronous, active low): queue empty, first_id and the ID counter
// return to 101, no result pending. Slot contents are not cleared; slots past
// the fill count are never read.
`default_nettype none

module stable_priority_queue_with_ids #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    spq_in_if.sink      i_in,
    spq_out_if.source   o_out,
    // Configuration port. Register 0 (first_id) lives at byte address 0.
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    // ------------------------------------------------------------------
    // Configuration: first_id also reloads the ID counter when written.
    // ------------------------------------------------------------------
    logic                       w_cfg_wr;
    logic [spq_pkg::ID_W-1:0]   r_first_id;
    logic [spq_pkg::ID_W-1:0]   r_id_ctr;
    logic [spq_pkg::ID_W-1:0]   n_id_ctr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && !paddr[2];
    assign prdata   = paddr[2] ? 32'd0 : {16'd0, r_first_id};

    // ------------------------------------------------------------------
    // Handshake: the output register frees itself when the result is
    // taken, so a new transaction is accepted in that same cycle. No
    // transaction is taken while reset is held.
    // ------------------------------------------------------------------
    logic w_accept;
    logic r_out_valid;

    assign i_in.ready = i_rst_n && (!r_out_valid || o_out.ready);
    assign w_accept   = i_in.valid && i_in.ready;

    // ------------------------------------------------------------------
    // Operation decode against the fill count.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              w_full;
    logic              w_empty;
    spq_pkg::t_cmd     w_cmd;
    spq_pkg::t_entry   w_new;
    spq_pkg::t_entry   w_cell [QUEUE_DEPTH];
    logic              w_keep [QUEUE_DEPTH];

    logic [spq_pkg::STAT_W-1:0] n_status;
    spq_pkg::t_entry            n_res;

    assign w_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_empty = (r_count == '0);

    assign w_new.id  = r_id_ctr;
    assign w_new.pri = i_in.priority_req;
    assign w_new.age = i_in.age;

    always_comb begin
        w_cmd.ins = 1'b0;
        w_cmd.rem = 1'b0;
        w_cmd.pri = i_in.priority_req;
        n_count   = r_count;
        n_status  = spq_pkg::ST_INSERTED;
        n_res     = '0;
        if (i_in.op == spq_pkg::OP_INSERT) begin
            if (w_full) begin
                // Queue full: nothing is stored and no ID is taken.
                n_status = spq_pkg::ST_FULL;
            end else begin
                w_cmd.ins = w_accept;
                n_status  = spq_pkg::ST_INSERTED;
                n_res     = w_new;
                n_count   = r_count + CNT_W'(1);
            end
        end else begin
            if (w_empty) begin
                n_status = spq_pkg::ST_EMPTY;
            end else begin
                w_cmd.rem = w_accept;
                n_status  = spq_pkg::ST_REMOVED;
                n_res     = w_cell[0];
                n_count   = r_count - CNT_W'(1);
            end
        end
    end

    always_comb begin
        n_id_ctr = r_id_ctr;
        if (w_cfg_wr) begin
            n_id_ctr = pwdata[spq_pkg::ID_W-1:0];
        end else if (w_cmd.ins) begin
            n_id_ctr = r_id_ctr + spq_pkg::ID_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Row of cells: slot 0 is the head. On insert each slot keeps its
    // entry, takes the new one or takes its left neighbor's; on remove
    // every slot takes its right neighbor's.
    // ------------------------------------------------------------------
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic            w_occ;
        logic            w_lkeep;
        spq_pkg::t_entry w_left;
        spq_pkg::t_entry w_right;

        assign w_occ = (CNT_W'(g) < r_count);

        if (g == 0) begin : g_head
            assign w_lkeep = 1'b1;
            assign w_left  = w_new;
        end else begin : g_body
            assign w_lkeep = w_keep[g-1];
            assign w_left  = w_cell[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_cell[g+1];
        end

        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_cmd       (w_cmd),
            .i_occ       (w_occ),
            .i_left_keep (w_lkeep),
            .i_new       (w_new),
            .i_left      (w_left),
            .i_right     (w_right),
            .o_keep      (w_keep[g]),
            .o_entry     (w_cell[g])
        );
    end

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_first_id  <= spq_pkg::FIRST_ID_RESET;
            r_id_ctr    <= spq_pkg::FIRST_ID_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                r_first_id <= pwdata[spq_pkg::ID_W-1:0];
            end
            r_id_ctr <= n_id_ctr;
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    logic [spq_pkg::STAT_W-1:0] r_status;
    spq_pkg::t_entry            r_res;
    logic [spq_pkg::OCC_W-1:0]  r_occ;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_res    <= n_res;
            r_occ    <= spq_pkg::OCC_W'(n_count);
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_status;
    assign o_out.entry_id       = r_res.id;
    assign o_out.entry_priority = r_res.pri;
    assign o_out.entry_age      = r_res.age;
    assign o_out.occupancy      = r_occ;

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_top: regression bench for the stable priority queue with IDs
// Drives insert and remove transactions with random gaps, programs first_id
// over the APB port between phases, and checks every result transaction
// against a sorted-queue predictor kept inside the bench.
// ============================================================================

module tb_top;

    localparam int unsigned QUEUE_DEPTH = 16;

    // APB byte addresses. Only first_id exists; the next word is unmapped and
    // any write there must leave the block untouched.
    localparam logic [2:0] ADDR_FIRST_ID = 3'd0;
    localparam logic [2:0] ADDR_UNMAPPED = 3'd4;

    localparam int LONG_HOLD_CYCLES = 300;
    localparam int RANDOM_PHASES    = 5;
    localparam int ITEMS_PER_PHASE  = 150;

    // One result transaction as the block should present it.
    typedef struct packed {
        logic [spq_pkg::STAT_W-1:0] status;
        logic [spq_pkg::ID_W-1:0]   id;
        logic [spq_pkg::PRI_W-1:0]  pri;
        logic [spq_pkg::AGE_W-1:0]  age;
        logic [spq_pkg::OCC_W-1:0]  occ;
    } reply_t;

    // One row of the opening script. When pinned is set the reply was worked
    // out by hand and replaces the predicted one.
    typedef struct {
        logic                      op;
        logic [spq_pkg::PRI_W-1:0] pri;
        logic [spq_pkg::AGE_W-1:0] age;
        bit                        pinned;
        reply_t                    reply;
    } script_row_t;

    // Settings of one random phase.
    typedef struct {
        logic [spq_pkg::ID_W-1:0] first_id;
        int                       insert_pct;
        int                       pri_lo;
        int                       pri_hi;
        int                       idle_max;
        bit                       long_hold;
        bit                       poke_unmapped;
    } phase_plan_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    spq_in_if  req_if ();
    spq_out_if rsp_if ();

    stable_priority_queue_with_ids #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 4 ns period: rising edge at 2 ns, falling edge at 4 ns, and so on.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: a sorted copy of the queue, its fill level, the next
    // sequence ID to hand out and the programmed first_id.
    // ------------------------------------------------------------------------
    spq_pkg::t_entry          sorted_entries [QUEUE_DEPTH];
    int                       entry_count;
    logic [spq_pkg::ID_W-1:0] next_seq_id;
    logic [spq_pkg::ID_W-1:0] first_id_shadow;

    // Replies owed by the block, oldest first.
    reply_t replies_due [$];

    int error_count = 0;

    // Shared pacing knobs. idle_max bounds the random wait of both sides;
    // hold_request asks the result side for one long hold-off.
    int idle_max     = 10;
    bit hold_request = 1'b0;

    function automatic void note_failure(string msg);
        error_count++;
        if (error_count <= 10) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
    endfunction

    function automatic void reset_predictor();
        int i;
        for (i = 0; i < QUEUE_DEPTH; i++) begin
            sorted_entries[i] = '0;
        end
        entry_count     = 0;
        first_id_shadow = spq_pkg::FIRST_ID_RESET;
        next_seq_id     = spq_pkg::FIRST_ID_RESET;
    endfunction

    // Applies one accepted request to the sorted copy and returns the reply.
    // An insert goes behind every entry of equal or smaller priority value, so
    // one priority level stays in arrival order. Errors change nothing.
    function automatic reply_t apply_request(logic op, logic [spq_pkg::PRI_W-1:0] pri,
                                             logic [spq_pkg::AGE_W-1:0] age);
        reply_t r;
        int     pos;
        int     i;
        r = '0;
        if (op == spq_pkg::OP_INSERT) begin
            if (entry_count >= QUEUE_DEPTH) begin
                r.status = spq_pkg::ST_FULL;
            end else begin
                pos = 0;
                while (pos < entry_count && sorted_entries[pos].pri <= pri) begin
                    pos++;
                end
                for (i = entry_count; i > pos; i--) begin
                    sorted_entries[i] = sorted_entries[i-1];
                end
                sorted_entries[pos].id  = next_seq_id;
                sorted_entries[pos].pri = pri;
                sorted_entries[pos].age = age;
                entry_count++;
                r.status    = spq_pkg::ST_INSERTED;
                r.id        = next_seq_id;
                r.pri       = pri;
                r.age       = age;
                next_seq_id = next_seq_id + spq_pkg::ID_W'(1);
            end
        end else if (entry_count == 0) begin
            r.status = spq_pkg::ST_EMPTY;
        end else begin
            r.status = spq_pkg::ST_REMOVED;
            r.id     = sorted_entries[0].id;
            r.pri    = sorted_entries[0].pri;
            r.age    = sorted_entries[0].age;
            for (i = 1; i < entry_count; i++) begin
                sorted_entries[i-1] = sorted_entries[i];
            end
            entry_count--;
        end
        r.occ = spq_pkg::OCC_W'(entry_count);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // APB access: setup phase at one falling edge, access phase at the next,
    // completion at the first rising edge with pready high.
    // ------------------------------------------------------------------------
    task automatic apb_transfer(input logic is_write, input logic [2:0] addr,
                                input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Writes a register and mirrors the effect in the predictor. Loading
    // first_id also restarts the ID counter; unmapped addresses are ignored.
    task automatic program_register(input logic [2:0] addr, input logic [31:0] value);
        logic [31:0] unused_rdata;
        apb_transfer(1'b1, addr, value, unused_rdata);
        if (addr == ADDR_FIRST_ID) begin
            first_id_shadow = value[spq_pkg::ID_W-1:0];
            next_seq_id     = value[spq_pkg::ID_W-1:0];
        end
    endtask

    task automatic check_first_id();
        logic [31:0] rdata;
        apb_transfer(1'b0, ADDR_FIRST_ID, 32'h0, rdata);
        if (rdata[spq_pkg::ID_W-1:0] !== first_id_shadow) begin
            note_failure($sformatf("first_id readback: expected %0d, got %0d",
                                   first_id_shadow, rdata[spq_pkg::ID_W-1:0]));
        end
    endtask

    // ------------------------------------------------------------------------
    // Request side. Each transaction waits a random number of cycles with
    // valid low (payload toggling as noise), then holds valid until ready.
    // Returns in the time step of the accepting rising edge. When the gap is
    // zero valid simply stays high from the previous transaction.
    // ------------------------------------------------------------------------
    task automatic offer_request(input logic op, input logic [spq_pkg::PRI_W-1:0] pri,
                                 input logic [spq_pkg::AGE_W-1:0] age);
        int gap;
        gap = $urandom_range(0, idle_max);
        @(negedge i_clk);
        if (gap > 0) begin
            req_if.valid        <= 1'b0;
            req_if.op           <= 1'($urandom);
            req_if.priority_req <= spq_pkg::PRI_W'($urandom);
            req_if.age          <= spq_pkg::AGE_W'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.op           <= op;
        req_if.priority_req <= pri;
        req_if.age          <= age;
        @(posedge i_clk);
        while (!req_if.ready) begin
            @(posedge i_clk);
        end
    endtask

    // Drops valid after the last transaction of a phase and waits until every
    // owed reply has come back, which leaves the block idle.
    task automatic settle_queue();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (replies_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side. Before each result transaction ready stays low for a random
    // number of cycles. Once, on request, it stays low for a long stretch so
    // that the output register backs up and the block stalls its input.
    // ------------------------------------------------------------------------
    initial begin : result_pacer
        int pause;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                pause        = LONG_HOLD_CYCLES;
            end else begin
                pause = $urandom_range(0, idle_max);
            end
            if (pause > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (pause) @(negedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!(i_rst_n && rsp_if.valid && rsp_if.ready)) begin
                @(posedge i_clk);
            end
        end
    end

    // Every accepted result transaction is compared field by field with the
    // oldest owed reply.
    always @(posedge i_clk) begin : reply_checker
        reply_t got;
        reply_t want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got.status = rsp_if.status;
            got.id     = rsp_if.entry_id;
            got.pri    = rsp_if.entry_priority;
            got.age    = rsp_if.entry_age;
            got.occ    = rsp_if.occupancy;
            if (replies_due.size() == 0) begin
                note_failure($sformatf({"result with none owed: ",
                                        "st=%0d id=%0d pri=%0d age=%0d occ=%0d"},
                                       got.status, got.id, got.pri, got.age, got.occ));
            end else begin
                want = replies_due.pop_front();
                if (got.status !== want.status || got.id !== want.id ||
                    got.pri !== want.pri || got.age !== want.age ||
                    got.occ !== want.occ) begin
                    note_failure($sformatf({"expected st=%0d id=%0d pri=%0d age=%0d occ=%0d, ",
                                            "got st=%0d id=%0d pri=%0d age=%0d occ=%0d"},
                                           want.status, want.id, want.pri, want.age, want.occ,
                                           got.status, got.id, got.pri, got.age, got.occ));
                end
            end
        end
    end

    // Hard stop, far beyond the slowest legal run.
    initial begin : watchdog
        #2_000_000;
        $display("stable_priority_queue_with_ids regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, opening script, then random phases that each
    // start from an idle block with a fresh first_id.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        script_row_t               opening_script [$];
        phase_plan_t               plans [RANDOM_PHASES];
        reply_t                    predicted;
        logic                      op;
        logic [spq_pkg::PRI_W-1:0] pri;
        logic [spq_pkg::AGE_W-1:0] age;
        int                        p;
        int                        n;

        // Every block input starts at a known value.
        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        req_if.valid        = 1'b0;
        req_if.op           = spq_pkg::OP_INSERT;
        req_if.priority_req = '0;
        req_if.age          = '0;
        rsp_if.ready        = 1'b0;
        reset_predictor();

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // After reset first_id must read back as its reset value.
        check_first_id();

        // Opening script, running on the reset first_id of 101. Remove from
        // an empty queue, the priority and age extremes, two equal-priority
        // pairs that must leave in arrival order, a fill to the brim, an
        // insert into the full queue, then removes that walk the sorted order.
        opening_script.push_back('{spq_pkg::OP_REMOVE, 4'd0,  8'd0,   1'b1,
                                   '{spq_pkg::ST_EMPTY,    16'd0,   4'd0,  8'd0,   5'd0}});
        opening_script.push_back('{spq_pkg::OP_INSERT, 4'd15, 8'd255, 1'b1,
                                   '{spq_pkg::ST_INSERTED, 16'd101, 4'd15, 8'd255, 5'd1}});
        opening_script.push_back('{spq_pkg::OP_INSERT, 4'd0,  8'd0,   1'b1,
                                   '{spq_pkg::ST_INSERTED, 16'd102, 4'd0,  8'd0,   5'd2}});
        opening_script.push_back('{spq_pkg::OP_INSERT, 4'd15, 8'd1,   1'b1,
                                   '{spq_pkg::ST_INSERTED, 16'd103, 4'd15, 8'd1,   5'd3}});
        opening_script.push_back('{spq_pkg::OP_INSERT, 4'd0,  8'd128, 1'b1,
                                   '{spq_pkg::ST_INSERTED, 16'd104, 4'd0,  8'd128, 5'd4}});
        opening_script.push_back('{spq_pkg::OP_INSERT, 4'd5,  8'h55, 1'b0, '0});
        opening_script.push_back('{spq_pkg::OP_INSERT, 4'd10, 8'haa, 1'b0, '0});
        opening_script.push_back('{spq_pkg::OP_INSERT, 4'd5,  8'h0f, 1'b0, '0});
        opening_script.push_back('{spq_pkg::OP_INSERT, 4'd0,  8'hf0, 1'b0, '0});
        opening_script.push_back('{spq_pkg::OP_INSERT, 4'd15, 8'h7f, 1'b0, '0});
        opening_script.push_back('{spq_pkg::OP_INSERT, 4'd8,  8'h80, 1'b0, '0});
        opening_script.push_back('{spq_pkg::OP_INSERT, 4'd1,  8'h01, 1'b0, '0});
        opening_script.push_back('{spq_pkg::OP_INSERT, 4'd5,  8'hfe, 1'b0, '0});
        opening_script.push_back('{spq_pkg::OP_INSERT, 4'd10, 8'h33, 1'b0, '0});
        opening_script.push_back('{spq_pkg::OP_INSERT, 4'd3,  8'hcc, 1'b0, '0});
        opening_script.push_back('{spq_pkg::OP_INSERT, 4'd14, 8'h66, 1'b0, '0});
        opening_script.push_back('{spq_pkg::OP_INSERT, 4'd6,  8'h99, 1'b0, '0});
        // Queue now holds sixteen entries: this insert is refused.
        opening_script.push_back('{spq_pkg::OP_INSERT, 4'd0,  8'hff, 1'b1,
                                   '{spq_pkg::ST_FULL,     16'd0,   4'd0,  8'd0,   5'd16}});
        repeat (7) opening_script.push_back('{spq_pkg::OP_REMOVE, 4'd0, 8'd0, 1'b0, '0});

        foreach (opening_script[i]) begin
            offer_request(opening_script[i].op, opening_script[i].pri,
                          opening_script[i].age);
            predicted = apply_request(opening_script[i].op, opening_script[i].pri,
                                      opening_script[i].age);
            if (opening_script[i].pinned) begin
                replies_due.push_back(opening_script[i].reply);
            end else begin
                replies_due.push_back(predicted);
            end
        end

        // Random phases. The ID counter wraps in the first and third phase;
        // the second fills the queue hard with no idling and one long result
        // hold-off; the third drains into empty removes and also pokes the
        // unmapped address; the fourth keeps priorities crowded at the top.
        plans[0] = '{16'd65530,                60, 0,  15, 10, 1'b0, 1'b0};
        plans[1] = '{16'd0,                    75, 0,  3,  0,  1'b1, 1'b0};
        plans[2] = '{16'd65535,                35, 0,  15, 10, 1'b0, 1'b1};
        plans[3] = '{spq_pkg::ID_W'($urandom), 50, 12, 15, 3,  1'b0, 1'b0};
        plans[4] = '{spq_pkg::ID_W'($urandom), 55, 0,  15, 10, 1'b0, 1'b0};

        for (p = 0; p < RANDOM_PHASES; p++) begin
            settle_queue();
            if (plans[p].poke_unmapped) begin
                program_register(ADDR_UNMAPPED, $urandom);
                check_first_id();
            end
            // Upper data bits are random; only the low 16 bits may count.
            program_register(ADDR_FIRST_ID,
                             {16'($urandom), plans[p].first_id});
            check_first_id();

            idle_max     = plans[p].idle_max;
            hold_request = plans[p].long_hold;
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                op  = ($urandom_range(0, 99) < plans[p].insert_pct) ?
                      spq_pkg::OP_INSERT : spq_pkg::OP_REMOVE;
                pri = spq_pkg::PRI_W'($urandom_range(plans[p].pri_lo, plans[p].pri_hi));
                age = spq_pkg::AGE_W'($urandom_range(0, 255));
                offer_request(op, pri, age);
                replies_due.push_back(apply_request(op, pri, age));
            end
        end

        settle_queue();
        repeat (8) @(posedge i_clk);

        if (error_count == 0 && replies_due.size() == 0) begin
            $display("stable_priority_queue_with_ids regression: pass");
        end else begin
            $display("stable_priority_queue_with_ids regression: fail");
        end
        $finish;
    end

endmodule
